@@ rtl/rau_pkg.sv @@
// rau_pkg: shared codes, state type and controller/datapath interface structs
// for the rational arithmetic unit. No dependencies.
`default_nettype none
package rau_pkg;

    localparam int DATA_W = 32;  // operand ports and result numerator port
    localparam int DEN_W  = 31;  // result denominator port
    localparam int OP_W   = 3;
    localparam int CMP_W  = 2;
    localparam int ST_W   = 2;

    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV = 3'd3;
    localparam logic [OP_W-1:0] OP_CMP = 3'd4;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_ZERO = 2'd1;
    localparam logic [ST_W-1:0] ST_OVF  = 2'd2;

    localparam logic [CMP_W-1:0] CMP_LT = 2'd0;
    localparam logic [CMP_W-1:0] CMP_EQ = 2'd1;
    localparam logic [CMP_W-1:0] CMP_GT = 2'd2;

    typedef enum logic [1:0] {
        MS_1,
        MS_2,
        MS_3
    } t_mul_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_COMBINE,
        S_GCD_INIT,
        S_GCD_SHIFT,
        S_GCD_LOOP,
        S_DIV_INIT,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     combine;
        logic     gcd_init;
        logic     gcd_shift;
        logic     gcd_step;
        logic     div_init;
        logic     div_step;
        logic     fin;
    } t_cmd;

    typedef struct packed {
        logic fail_early;
        logic is_cmp;
        logic num_zero;
        logic both_even;
        logic gcd_done;
        logic div_last;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

@@ rtl/rau_ctrl.sv @@
// rau_ctrl: sequencing state machine for the rational arithmetic unit.
// Depends on rau_pkg (state enum, command and status structs).
`default_nettype none
module rau_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire rau_pkg::t_stat i_stat,
    output rau_pkg::t_cmd      o_cmd,
    output logic               o_busy
);

    rau_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rau_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != rau_pkg::S_IDLE);
        unique case (r_state)
            rau_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = rau_pkg::S_CHECK;
                end
            end
            rau_pkg::S_CHECK: begin
                n_state = i_stat.fail_early ? rau_pkg::S_FIN : rau_pkg::S_MUL1;
            end
            rau_pkg::S_MUL1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = rau_pkg::MS_1;
                n_state       = rau_pkg::S_MUL2;
            end
            rau_pkg::S_MUL2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = rau_pkg::MS_2;
                n_state       = rau_pkg::S_MUL3;
            end
            rau_pkg::S_MUL3: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = rau_pkg::MS_3;
                n_state       = rau_pkg::S_COMBINE;
            end
            rau_pkg::S_COMBINE: begin
                o_cmd.combine = 1'b1;
                n_state       = rau_pkg::S_GCD_INIT;
            end
            rau_pkg::S_GCD_INIT: begin
                // compare and zero results need no reduction
                if (i_stat.is_cmp || i_stat.num_zero) begin
                    n_state = rau_pkg::S_FIN;
                end else begin
                    o_cmd.gcd_init = 1'b1;
                    n_state        = rau_pkg::S_GCD_SHIFT;
                end
            end
            rau_pkg::S_GCD_SHIFT: begin
                if (i_stat.both_even) begin
                    o_cmd.gcd_shift = 1'b1;
                end else begin
                    n_state = rau_pkg::S_GCD_LOOP;
                end
            end
            rau_pkg::S_GCD_LOOP: begin
                if (i_stat.gcd_done) begin
                    n_state = rau_pkg::S_DIV_INIT;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            rau_pkg::S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = rau_pkg::S_DIV;
            end
            rau_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = rau_pkg::S_FIN;
                end
            end
            rau_pkg::S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = rau_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rau_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/rau_datapath.sv @@
// rau_datapath: operand registers, shared multiplier, binary GCD, dual
// restoring divider and result register. Depends on rau_pkg.
`default_nettype none
module rau_datapath #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rau_pkg::t_cmd                 i_cmd,
    output rau_pkg::t_stat                     o_stat,
    input  wire logic [rau_pkg::OP_W-1:0]      i_req_type,
    input  wire logic [rau_pkg::DATA_W-1:0]    i_a_num,
    input  wire logic [rau_pkg::DATA_W-1:0]    i_a_den,
    input  wire logic [rau_pkg::DATA_W-1:0]    i_b_num,
    input  wire logic [rau_pkg::DATA_W-1:0]    i_b_den,
    input  wire logic                          i_stall,
    output logic                               o_valid,
    output logic signed [rau_pkg::DATA_W-1:0]  o_res_num,
    output logic [rau_pkg::DEN_W-1:0]          o_res_den,
    output logic [rau_pkg::CMP_W-1:0]          o_cmp_result,
    output logic [rau_pkg::ST_W-1:0]           o_status
);

    localparam int W  = VALUE_WIDTH;
    localparam int PW = 2 * VALUE_WIDTH;
    localparam int KW = $clog2(PW);
    localparam logic [PW-1:0] LIM = PW'(1) << (W - 1);

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
        mag_of = v[W-1] ? (~v + 1'b1) : v;
    endfunction

    // operands
    logic [rau_pkg::OP_W-1:0] r_op;
    logic [W-1:0] r_an, r_ad, r_bn, r_bd;
    logic r_sa, r_sb, r_bad_op, r_zero_den, r_div_zero;

    // products and combined fraction
    logic [PW-1:0] r_p1, r_p2, r_p3;
    logic [PW-1:0] r_num_mag, r_den_mag;
    logic r_num_neg;
    logic [rau_pkg::CMP_W-1:0] r_cmp;

    // gcd and divider
    logic [PW-1:0] r_u, r_v, r_g;
    logic [KW-1:0] r_k, r_cnt;
    logic [PW-1:0] r_qn, r_qd, r_rn, r_rd;

    logic r_out_valid;
    logic signed [rau_pkg::DATA_W-1:0] r_res_num;
    logic [rau_pkg::DEN_W-1:0] r_res_den;
    logic [rau_pkg::CMP_W-1:0] r_res_cmp;
    logic [rau_pkg::ST_W-1:0]  r_res_st;

    logic [W-1:0] an_v, ad_v, bn_v, bd_v;
    logic [W-1:0] mx, my;
    logic [PW-1:0] prod;
    logic signed [PW:0] s1, s2, sum;
    logic [PW:0] tn, td;
    logic ovf;
    logic [rau_pkg::DATA_W-1:0] num32;

    assign an_v = i_a_num[W-1:0];
    assign ad_v = i_a_den[W-1:0];
    assign bn_v = i_b_num[W-1:0];
    assign bd_v = i_b_den[W-1:0];

    // shared multiplier operand select
    always_comb begin
        mx = r_an;
        my = r_bd;
        unique case (i_cmd.mul_sel)
            rau_pkg::MS_1: begin
                mx = r_an;
                my = (r_op == rau_pkg::OP_MUL) ? r_bn : r_bd;
            end
            rau_pkg::MS_2: begin
                mx = r_bn;
                my = r_ad;
            end
            rau_pkg::MS_3: begin
                mx = r_ad;
                my = (r_op == rau_pkg::OP_DIV) ? r_bn : r_bd;
            end
            default: begin
                mx = r_an;
                my = r_bd;
            end
        endcase
    end

    assign prod = PW'(mx) * PW'(my);

    assign s1  = r_sa ? -$signed({1'b0, r_p1}) : $signed({1'b0, r_p1});
    assign s2  = r_sb ? -$signed({1'b0, r_p2}) : $signed({1'b0, r_p2});
    assign sum = (r_op == rau_pkg::OP_ADD) ? (s1 + s2) : (s1 - s2);

    assign tn = {r_rn, r_qn[PW-1]};
    assign td = {r_rd, r_qd[PW-1]};

    assign ovf = (r_qd > (LIM - 1'b1)) || (r_qn > (r_num_neg ? LIM : (LIM - 1'b1)));
    assign num32 = rau_pkg::DATA_W'(r_qn);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_req_type;
            r_an       <= mag_of(an_v);
            r_ad       <= mag_of(ad_v);
            r_bn       <= mag_of(bn_v);
            r_bd       <= mag_of(bd_v);
            r_sa       <= an_v[W-1] ^ ad_v[W-1];
            r_sb       <= bn_v[W-1] ^ bd_v[W-1];
            r_bad_op   <= (i_req_type > rau_pkg::OP_CMP);
            r_zero_den <= (ad_v == '0) || (bd_v == '0);
            r_div_zero <= (i_req_type == rau_pkg::OP_DIV) && (bn_v == '0);
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                rau_pkg::MS_1: r_p1 <= prod;
                rau_pkg::MS_2: r_p2 <= prod;
                default:       r_p3 <= prod;
            endcase
        end
        if (i_cmd.combine) begin
            r_den_mag <= r_p3;
            if (r_op == rau_pkg::OP_MUL || r_op == rau_pkg::OP_DIV) begin
                r_num_mag <= r_p1;
                r_num_neg <= r_sa ^ r_sb;
            end else begin
                r_num_mag <= PW'(sum[PW] ? -sum : sum);
                r_num_neg <= sum[PW];
            end
            if (sum == '0) begin
                r_cmp <= rau_pkg::CMP_EQ;
            end else if (sum[PW]) begin
                r_cmp <= rau_pkg::CMP_LT;
            end else begin
                r_cmp <= rau_pkg::CMP_GT;
            end
        end
        // binary gcd: strip common twos, then subtract odd values
        if (i_cmd.gcd_init) begin
            r_u <= r_num_mag;
            r_v <= r_den_mag;
            r_k <= '0;
        end else if (i_cmd.gcd_shift) begin
            r_u <= r_u >> 1;
            r_v <= r_v >> 1;
            r_k <= r_k + 1'b1;
        end else if (i_cmd.gcd_step) begin
            if (!r_u[0]) begin
                r_u <= r_u >> 1;
            end else if (!r_v[0]) begin
                r_v <= r_v >> 1;
            end else if (r_u >= r_v) begin
                r_u <= r_u - r_v;
            end else begin
                r_v <= r_v - r_u;
            end
        end
        // exact division of both terms by the gcd, one bit per cycle
        if (i_cmd.div_init) begin
            r_g   <= (r_u | r_v) << r_k;
            r_qn  <= r_num_mag;
            r_qd  <= r_den_mag;
            r_rn  <= '0;
            r_rd  <= '0;
            r_cnt <= KW'(PW - 1);
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt - 1'b1;
            if (tn >= {1'b0, r_g}) begin
                r_rn <= PW'(tn - {1'b0, r_g});
                r_qn <= {r_qn[PW-2:0], 1'b1};
            end else begin
                r_rn <= PW'(tn);
                r_qn <= {r_qn[PW-2:0], 1'b0};
            end
            if (td >= {1'b0, r_g}) begin
                r_rd <= PW'(td - {1'b0, r_g});
                r_qd <= {r_qd[PW-2:0], 1'b1};
            end else begin
                r_rd <= PW'(td);
                r_qd <= {r_qd[PW-2:0], 1'b0};
            end
        end
        if (i_cmd.fin) begin
            r_res_num <= '0;
            r_res_den <= '0;
            r_res_cmp <= rau_pkg::CMP_LT;
            r_res_st  <= rau_pkg::ST_OK;
            if (r_bad_op) begin
                r_res_st <= rau_pkg::ST_OK;
            end else if (r_zero_den || r_div_zero) begin
                r_res_st <= rau_pkg::ST_ZERO;
            end else if (r_op == rau_pkg::OP_CMP) begin
                r_res_cmp <= r_cmp;
            end else if (r_num_mag == '0) begin
                r_res_den <= rau_pkg::DEN_W'(1);
            end else if (ovf) begin
                r_res_st <= rau_pkg::ST_OVF;
            end else begin
                r_res_num <= r_num_neg ? -$signed(num32) : $signed(num32);
                r_res_den <= rau_pkg::DEN_W'(r_qd);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_stat.fail_early = r_bad_op || r_zero_den || r_div_zero;
        o_stat.is_cmp     = (r_op == rau_pkg::OP_CMP);
        o_stat.num_zero   = (r_num_mag == '0);
        o_stat.both_even  = !r_u[0] && !r_v[0];
        o_stat.gcd_done   = (r_u == '0) || (r_v == '0);
        o_stat.div_last   = (r_cnt == '0);
        o_stat.out_free   = !r_out_valid || !i_stall;
    end

    assign o_valid      = r_out_valid;
    assign o_res_num    = r_res_num;
    assign o_res_den    = r_res_den;
    assign o_cmp_result = r_res_cmp;
    assign o_status     = r_res_st;

endmodule
`default_nettype wire

@@ rtl/rational_arithmetic_unit.sv @@
// rational_arithmetic_unit: top level, joins controller and datapath.
// Depends on rau_pkg, rau_ctrl, rau_datapath.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  request | in        | i_valid / o_stall  | i_req_type, i_a_num, i_a_den,
//          |           |                    | i_b_num, i_b_den
//  result  | out       | o_valid / i_stall  | o_res_num, o_res_den, o_cmp_result,
//          |           |                    | o_status
//
// One item at a time. Errors and unused opcodes go from the check state straight
// to the final state; compare and zero results skip the GCD and the divider.
// Reduced results pass through the multiplies, the combine, the binary GCD (one
// shift or subtract per cycle) and the bit-serial divider; the GCD loop and the
// bit-serial divider dominate the run time.
// Reset (synchronous, i_rst_n low) clears the sequencer and the result valid.
// A finished result is held in the output register; the next item is taken
// while it waits, and its own result waits in the last state until the
// register is free.
`default_nettype none
module rational_arithmetic_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [rau_pkg::OP_W-1:0]      i_req_type,
    input  wire logic signed [rau_pkg::DATA_W-1:0] i_a_num,
    input  wire logic signed [rau_pkg::DATA_W-1:0] i_a_den,
    input  wire logic signed [rau_pkg::DATA_W-1:0] i_b_num,
    input  wire logic signed [rau_pkg::DATA_W-1:0] i_b_den,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed [rau_pkg::DATA_W-1:0]  o_res_num,
    output logic [rau_pkg::DEN_W-1:0]          o_res_den,
    output logic [rau_pkg::CMP_W-1:0]          o_cmp_result,
    output logic [rau_pkg::ST_W-1:0]           o_status
);

    rau_pkg::t_cmd  cmd;
    rau_pkg::t_stat stat;

    // the sequencer only takes an item in its idle state
    rau_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_stall)
    );

    rau_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_req_type   (i_req_type),
        .i_a_num      (i_a_num),
        .i_a_den      (i_a_den),
        .i_b_num      (i_b_num),
        .i_b_den      (i_b_den),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_res_num    (o_res_num),
        .o_res_den    (o_res_den),
        .o_cmp_result (o_cmp_result),
        .o_status     (o_status)
    );

endmodule
`default_nettype wire

@@ rtl/rau_checker.sv @@
// rau_checker: port-level assertions for rational_arithmetic_unit and the
// bind that attaches them. Depends on rau_pkg.
`default_nettype none
module rau_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_valid,
    input wire logic                          o_stall,
    input wire logic                          o_valid,
    input wire logic                          i_stall,
    input wire logic [rau_pkg::DATA_W-1:0]    o_res_num,
    input wire logic [rau_pkg::DEN_W-1:0]     o_res_den,
    input wire logic [rau_pkg::CMP_W-1:0]     o_cmp_result,
    input wire logic [rau_pkg::ST_W-1:0]      o_status
);

    // an accepted item keeps the unit busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("item accepted but unit not busy");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_res_num) && $stable(o_res_den)
            && $stable(o_status) && $stable(o_cmp_result)))
        else $error("stalled result changed");

    // errors carry no fraction
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != rau_pkg::ST_OK) |->
            (o_res_num == '0 && o_res_den == '0 && o_cmp_result == rau_pkg::CMP_LT))
        else $error("error result carries data");

    // a fraction result never carries a compare outcome, and a zero is 0/1
    a_frac_no_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res_den != '0) |->
            (o_cmp_result == rau_pkg::CMP_LT && o_status == rau_pkg::ST_OK
             && (o_res_num != '0 || o_res_den == 31'd1)))
        else $error("bad fraction result");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);
`default_nettype wire

@@ bench/tb.sv @@
// tb: self-checking bench for rational_arithmetic_unit (fraction add/sub/mul/div/compare).
// Depends on rau_pkg and the rational_arithmetic_unit RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb;

    localparam int IDLE_MAX  = 14;
    localparam int WDOG_MAX  = 20000;  // cycles with no handshake before giving up
    localparam int DRAIN_CYC = 400;    // idle wait after the last expected result has arrived

    typedef struct packed {
        logic signed [rau_pkg::DATA_W-1:0] num;
        logic [rau_pkg::DEN_W-1:0]         den;
        logic [rau_pkg::CMP_W-1:0]         cmp;
        logic [rau_pkg::ST_W-1:0]          st;
    } t_frac_res;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              req_valid = 1'b0;
    logic                              req_stall;
    logic [rau_pkg::OP_W-1:0]          req_type = '0;
    logic signed [rau_pkg::DATA_W-1:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
    logic                              res_valid;
    logic                              res_stall = 1'b0;
    logic signed [rau_pkg::DATA_W-1:0] res_num;
    logic [rau_pkg::DEN_W-1:0]         res_den;
    logic [rau_pkg::CMP_W-1:0]         res_cmp;
    logic [rau_pkg::ST_W-1:0]          res_st;

    t_frac_res pending_q[$];
    int        n_err = 0;
    int        n_items = 0;
    int        n_results = 0;
    int        idle_cycles = 0;
    int        op_seen[8];

    always #5 clk = ~clk;

    rational_arithmetic_unit u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(req_valid), .o_stall(req_stall),
        .i_req_type(req_type), .i_a_num(a_num), .i_a_den(a_den),
        .i_b_num(b_num), .i_b_den(b_den),
        .o_valid(res_valid), .i_stall(res_stall),
        .o_res_num(res_num), .o_res_den(res_den),
        .o_cmp_result(res_cmp), .o_status(res_st)
    );

    // --- predictor: sign-magnitude arithmetic in 64 bits ---
    typedef struct packed {
        logic        neg;
        logic [63:0] mag;
    } t_sm;

    function automatic t_sm to_sm(logic [31:0] v);
        t_sm r;
        r.neg = v[31];
        r.mag = v[31] ? (64'd1 << 32) - {32'd0, v} : {32'd0, v};
        return r;
    endfunction

    function automatic t_sm sm_times(t_sm x, t_sm y);
        t_sm r;
        r.mag = x.mag * y.mag;
        r.neg = (r.mag != 0) && (x.neg != y.neg);
        return r;
    endfunction

    function automatic t_sm sm_plus(t_sm x, t_sm y);
        t_sm r;
        if (x.neg == y.neg) begin
            r.mag = x.mag + y.mag;
            r.neg = x.neg;
        end else if (x.mag >= y.mag) begin
            r.mag = x.mag - y.mag;
            r.neg = x.neg;
        end else begin
            r.mag = y.mag - x.mag;
            r.neg = y.neg;
        end
        if (r.mag == 0) r.neg = 1'b0;
        return r;
    endfunction

    function automatic t_sm sm_flip(t_sm x);
        x.neg = (x.mag != 0) && !x.neg;
        return x;
    endfunction

    function automatic logic [63:0] euclid(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic t_frac_res predict_fraction(logic [rau_pkg::OP_W-1:0] op,
                                                   logic [31:0] an_r, logic [31:0] ad_r,
                                                   logic [31:0] bn_r, logic [31:0] bd_r);
        t_frac_res   r;
        t_sm         an, ad, bn, bd, nm, dn, t;
        logic [63:0] g;
        logic [63:0] lim;
        r   = '0;
        lim = 64'd1 << 31;
        an  = to_sm(an_r);
        ad  = to_sm(ad_r);
        bn  = to_sm(bn_r);
        bd  = to_sm(bd_r);
        if (op > rau_pkg::OP_CMP) return r;
        if (ad.mag == 0 || bd.mag == 0) begin
            r.st = rau_pkg::ST_ZERO;
            return r;
        end
        if (ad.neg) begin ad.neg = 1'b0; an = sm_flip(an); end
        if (bd.neg) begin bd.neg = 1'b0; bn = sm_flip(bn); end
        case (op)
            rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
                t = sm_times(bn, ad);
                if (op == rau_pkg::OP_SUB) t = sm_flip(t);
                nm = sm_plus(sm_times(an, bd), t);
                dn = sm_times(ad, bd);
            end
            rau_pkg::OP_MUL: begin
                nm = sm_times(an, bn);
                dn = sm_times(ad, bd);
            end
            rau_pkg::OP_DIV: begin
                if (bn.mag == 0) begin
                    r.st = rau_pkg::ST_ZERO;
                    return r;
                end
                nm = sm_times(an, bd);
                dn = sm_times(ad, bn);
                if (dn.neg) begin dn.neg = 1'b0; nm = sm_flip(nm); end
            end
            default: begin
                t = sm_plus(sm_times(an, bd), sm_flip(sm_times(bn, ad)));
                r.cmp = (t.mag == 0) ? rau_pkg::CMP_EQ
                                     : (t.neg ? rau_pkg::CMP_LT : rau_pkg::CMP_GT);
                return r;
            end
        endcase
        if (nm.mag == 0) begin
            r.den = rau_pkg::DEN_W'(1);
            return r;
        end
        g = euclid(nm.mag, dn.mag);
        nm.mag = nm.mag / g;
        dn.mag = dn.mag / g;
        if (dn.mag > lim - 1 || nm.mag > (nm.neg ? lim : lim - 1)) begin
            r.st = rau_pkg::ST_OVF;
            return r;
        end
        r.num = nm.neg ? -nm.mag[31:0] : nm.mag[31:0];
        r.den = dn.mag[30:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on result %0d: %s got %0d expected %0d", n_results, what, got,
                 want);
        n_err++;
    endtask

    // Result side: random stall per result, check at rising edge.
    initial begin : result_checker
        t_frac_res want;
        int        hold;
        forever begin
            @(negedge clk);
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, IDLE_MAX);
            res_stall <= (hold != 0);
            while (hold > 0) begin
                @(negedge clk);
                hold--;
                if (hold == 0) res_stall <= 1'b0;
            end
            do @(posedge clk); while (!(res_valid && !res_stall && rst_n));
            if (pending_q.size() == 0) begin
                $display("result %0d arrived with nothing expected", n_results);
                n_err++;
            end else begin
                want = pending_q.pop_front();
                if (res_num !== want.num) report_mismatch("res_num", res_num, want.num);
                if (res_den !== want.den) report_mismatch("res_den", res_den, want.den);
                if (res_cmp !== want.cmp) report_mismatch("cmp_result", res_cmp, want.cmp);
                if (res_st !== want.st) report_mismatch("status", res_st, want.st);
            end
            n_results++;
        end
    end

    // Watchdog: cycles without any handshake.
    always @(posedge clk) begin
        if ((req_valid && !req_stall) || (res_valid && !res_stall) || !rst_n)
            idle_cycles <= 0;
        else if (++idle_cycles >= WDOG_MAX) begin
            $display("watchdog expired");
            $display("tb NOT OK");
            $finish;
        end
    end

    // Send one item after a random gap; prediction is queued on acceptance.
    // Valid stays high from one item to the next when the gap is zero.
    task automatic send_fraction(logic [rau_pkg::OP_W-1:0] op, logic [31:0] an,
                                 logic [31:0] ad, logic [31:0] bn, logic [31:0] bd);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, IDLE_MAX);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_type  <= op;
        a_num     <= an;
        a_den     <= ad;
        b_num     <= bn;
        b_den     <= bd;
        do @(posedge clk); while (req_stall);
        pending_q.push_back(predict_fraction(op, an, ad, bn, bd));
        op_seen[op]++;
        n_items++;
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 20) - 10;
            1: return $urandom_range(0, 2000) - 1000;
            2: return $urandom_range(0, 131072) - 65536;
            3: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF}
                      - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        logic [rau_pkg::OP_W-1:0] op;
        for (int k = 0; k <= rau_pkg::OP_CMP; k++) begin
            op = rau_pkg::OP_W'(k);
            send_fraction(op, 1, 2, 1, 3);
            send_fraction(op, 32'h8000_0000, 1, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        end
        send_fraction(rau_pkg::OP_ADD, 3, 0, 1, 2);              // zero denominator on a
        send_fraction(rau_pkg::OP_CMP, 3, 5, 1, 0);              // zero denominator on b
        send_fraction(rau_pkg::OP_DIV, 3, 5, 0, 7);              // division by zero
        send_fraction(rau_pkg::OP_SUB, 2, 4, 1, 2);              // zero result -> 0/1
        send_fraction(rau_pkg::OP_MUL, 32'h7FFF_FFFF, 1, 2, 1);  // overflow
        send_fraction(rau_pkg::OP_MUL, 32'h8000_0000, 1, -1, 1); // 2^31 does not fit
        send_fraction(rau_pkg::OP_DIV, -1, 32'h8000_0000, 1, 1); // denominator too large
        send_fraction(rau_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF);
        send_fraction(rau_pkg::OP_CMP, 1, 3, 2, 6);              // equal
        // unused opcodes, also with zero denominators
        for (int k = rau_pkg::OP_CMP + 1; k < (1 << rau_pkg::OP_W); k++) begin
            op = rau_pkg::OP_W'(k);
            send_fraction(op, 1, 1, 1, 1);
            send_fraction(op, 0, 0, 0, 0);
        end
    endtask

    task automatic test_random(int count);
        logic [rau_pkg::OP_W-1:0] op;
        logic [31:0]              ad, bd;
        for (int k = 0; k < count; k++) begin
            op = ($urandom_range(0, 15) == 0) ? rau_pkg::OP_W'($urandom_range(0, 7))
                                              : rau_pkg::OP_W'($urandom_range(0, 4));
            ad = rand_value();
            bd = rand_value();
            if ($urandom_range(0, 30) == 0) ad = 0;
            if ($urandom_range(0, 30) == 0) bd = 0;
            send_fraction(op, rand_value(), ad, ($urandom_range(0, 20) == 0) ? 0 : rand_value(),
                          bd);
        end
    endtask

    initial begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random(1600);
        req_valid <= 1'b0;
        while (pending_q.size() != 0) @(negedge clk);
        repeat (DRAIN_CYC) @(negedge clk);
        $display("covered %0d items, %0d results: add %0d sub %0d mul %0d div %0d cmp %0d",
                 n_items, n_results, op_seen[0], op_seen[1], op_seen[2], op_seen[3],
                 op_seen[4]);
        $display("unused opcodes %0d, errors %0d", op_seen[5] + op_seen[6] + op_seen[7],
                 n_err);
        if (n_err == 0 && pending_q.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
`default_nettype wire
